// ----- rtl/twm_pkg.sv -----
`timescale 1ns / 1ps

package twm_pkg;

	localparam int MAX_SLICES = 7;
	localparam int SLICE_W    = 3;
	localparam int DATA_W     = 32;
	localparam int WT_W       = 48;
	localparam int ACC_W      = 64;
	localparam int CFG_IDX_W  = 3;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 3'd0;
	// Coefficient of slice n sits at this index plus n.
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_0     = 3'd1;

	localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;

	// How the back end treats a queued sample.
	typedef enum logic [1:0] {
		KIND_SKIP  = 2'd0, // contributes nothing
		KIND_UNITY = 2'd1, // root sample with zero coefficient, weight 1.0
		KIND_SELF  = 2'd2, // root sample, weight 1/coeff
		KIND_NEIGH = 2'd3  // neighbour sample, weight 1/(1/link + coeff)
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               neg;
		logic [DATA_W-1:0]  mag;
		logic [DATA_W-1:0]  link;
		logic [DATA_W-1:0]  coeff;
		logic               last;
	} entry_t;

endpackage

// ----- rtl/twm_front.sv -----
`timescale 1ns / 1ps

module twm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [twm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [twm_pkg::DATA_W-1:0]    cfg_data,
	input  logic [twm_pkg::DATA_W-1:0]    sample_value,
	input  logic [twm_pkg::DATA_W-1:0]    link_weight,
	input  logic [twm_pkg::SLICE_W-1:0]   slice_index,
	input  logic                          is_self,
	input  logic                          last_sample,
	output twm_pkg::entry_t               entry
);
	import twm_pkg::*;

	logic [SLICE_W-1:0] slice_count_q;
	logic [DATA_W-1:0]  coeff_q [MAX_SLICES];
	logic               in_window;
	logic [DATA_W-1:0]  coeff_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_count_q <= SLICE_W'(1);
			for (int i = 0; i < MAX_SLICES; i++) begin
				coeff_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == REG_SLICE_COUNT) begin
				slice_count_q <= cfg_data[SLICE_W-1:0];
			end else begin
				coeff_q[cfg_index - REG_COEFF_0] <= cfg_data;
			end
		end
	end

	assign in_window = (slice_index < slice_count_q) && (slice_index < SLICE_W'(MAX_SLICES));
	assign coeff_sel = in_window ? coeff_q[slice_index] : '0;

	always_comb begin
		entry.neg   = sample_value[DATA_W-1];
		entry.mag   = sample_value[DATA_W-1] ? (~sample_value + DATA_W'(1)) : sample_value;
		entry.link  = link_weight;
		entry.coeff = coeff_sel;
		entry.last  = last_sample;
		if (!in_window) begin
			entry.kind = KIND_SKIP;
		end else if (is_self) begin
			entry.kind = (coeff_sel == '0) ? KIND_UNITY : KIND_SELF;
		end else if (link_weight == '0) begin
			entry.kind = KIND_SKIP;
		end else begin
			entry.kind = KIND_NEIGH;
		end
	end

endmodule

// ----- rtl/twm_queue.sv -----
`timescale 1ns / 1ps

module twm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  twm_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output twm_pkg::entry_t head
);
	import twm_pkg::*;

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ----- rtl/twm_back.sv -----
`timescale 1ns / 1ps

module twm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  twm_pkg::entry_t            q_head,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [twm_pkg::DATA_W-1:0] out_mean,
	output logic                       out_error
);
	import twm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INV,
		ST_WGT,
		ST_MUL,
		ST_ACC,
		ST_MEAN,
		ST_OUT
	} state_t;

	localparam logic [ACC_W-1:0] RECIP_DVD = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [6:0]       RECIP_STEPS = 7'd33;
	localparam logic [6:0]       MEAN_STEPS  = 7'd64;

	state_t             state_q;
	logic               neg_q;
	logic               last_q;
	logic [DATA_W-1:0]  mag_q;
	logic [DATA_W-1:0]  coeff_q;
	logic [DATA_W-1:0]  w_q;
	logic [ACC_W-1:0]   prod_q;
	logic [WT_W-1:0]    wt_total_q;
	logic [ACC_W-1:0]   wv_total_q;
	logic [WT_W:0]      rem_q;
	logic [ACC_W-1:0]   dvd_q;
	logic [WT_W-1:0]    dsr_q;
	logic [6:0]         cnt_q;
	logic [DATA_W-1:0]  res_q;
	logic               err_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_mean_q;
	logic               out_err_q;
	logic               out_load;

	// One restoring division step.
	logic [WT_W:0]      rem_sh;
	logic               ge;
	logic [WT_W:0]      rem_nx;
	logic [ACC_W-1:0]   dvd_nx;
	logic [32:0]        q33;
	logic [DATA_W-1:0]  w_sat;
	logic [33:0]        d_sum;

	// Accumulation.
	logic [WT_W:0]      wt_sum;
	logic [ACC_W-1:0]   p_signed;
	logic [ACC_W:0]     wv_sum;
	logic [ACC_W-1:0]   wv_next;
	logic [DATA_W-1:0]  mean_sat;

	assign rem_sh = {rem_q[WT_W-1:0], dvd_q[ACC_W-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	assign dvd_nx = {dvd_q[ACC_W-2:0], ge};
	assign q33    = dvd_nx[32:0];
	assign w_sat  = q33[32] ? {DATA_W{1'b1}} : q33[DATA_W-1:0];
	assign d_sum  = {1'b0, q33} + {2'b00, coeff_q};

	assign wt_sum   = {1'b0, wt_total_q} + {{(WT_W-DATA_W+1){1'b0}}, w_q};
	assign p_signed = neg_q ? (~prod_q + ACC_W'(1)) : prod_q;
	assign wv_sum   = {wv_total_q[ACC_W-1], wv_total_q} + {p_signed[ACC_W-1], p_signed};

	always_comb begin
		if (wv_sum[ACC_W] != wv_sum[ACC_W-1]) begin
			wv_next = wv_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			wv_next = wv_sum[ACC_W-1:0];
		end
	end

	// Quotient of the mean, saturated to the signed result range.
	always_comb begin
		if (wv_total_q[ACC_W-1]) begin
			if (dvd_nx > ACC_W'(64'h8000_0000)) begin
				mean_sat = 32'h8000_0000;
			end else begin
				mean_sat = ~dvd_nx[DATA_W-1:0] + DATA_W'(1);
			end
		end else begin
			if (dvd_nx > ACC_W'(64'h7FFF_FFFF)) begin
				mean_sat = 32'h7FFF_FFFF;
			end else begin
				mean_sat = dvd_nx[DATA_W-1:0];
			end
		end
	end

	// A finished result moves to the output register once that register is free.
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_mean  = out_mean_q;
	assign out_error = out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_mean_q  <= '0;
			out_err_q   <= 1'b0;
			wt_total_q  <= '0;
			wv_total_q  <= '0;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			last_q      <= 1'b0;
			mag_q       <= '0;
			coeff_q     <= '0;
			w_q         <= '0;
			prod_q      <= '0;
			rem_q       <= '0;
			dvd_q       <= '0;
			dsr_q       <= '0;
			res_q       <= '0;
			err_q       <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						neg_q   <= q_head.neg;
						mag_q   <= q_head.mag;
						coeff_q <= q_head.coeff;
						last_q  <= q_head.last;
						rem_q   <= '0;
						dvd_q   <= RECIP_DVD;
						cnt_q   <= RECIP_STEPS;
						unique case (q_head.kind)
							KIND_UNITY: begin
								w_q     <= ONE_Q16;
								state_q <= ST_MUL;
							end
							KIND_SELF: begin
								dsr_q   <= WT_W'(q_head.coeff);
								state_q <= ST_WGT;
							end
							KIND_NEIGH: begin
								dsr_q   <= WT_W'(q_head.link);
								state_q <= ST_INV;
							end
							default: begin
								// Nothing to add: go straight to the end-of-set check.
								w_q     <= '0;
								prod_q  <= '0;
								state_q <= ST_ACC;
							end
						endcase
					end
				end
				ST_INV: begin
					if (cnt_q == 7'd1) begin
						dsr_q   <= WT_W'(d_sum);
						rem_q   <= '0;
						dvd_q   <= RECIP_DVD;
						cnt_q   <= RECIP_STEPS;
						state_q <= ST_WGT;
					end else begin
						rem_q <= rem_nx;
						dvd_q <= dvd_nx;
						cnt_q <= cnt_q - 7'd1;
					end
				end
				ST_WGT: begin
					if (cnt_q == 7'd1) begin
						w_q     <= w_sat;
						state_q <= ST_MUL;
					end else begin
						rem_q <= rem_nx;
						dvd_q <= dvd_nx;
						cnt_q <= cnt_q - 7'd1;
					end
				end
				ST_MUL: begin
					prod_q  <= ACC_W'(mag_q) * ACC_W'(w_q);
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					wt_total_q <= wt_sum[WT_W] ? {WT_W{1'b1}} : wt_sum[WT_W-1:0];
					wv_total_q <= wv_next;
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (wt_sum == '0) begin
						res_q   <= '0;
						err_q   <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						dsr_q   <= wt_sum[WT_W] ? {WT_W{1'b1}} : wt_sum[WT_W-1:0];
						state_q <= ST_MEAN;
					end
					// The mean divider starts on the updated totals in the next cycle.
					rem_q <= '0;
					cnt_q <= MEAN_STEPS;
				end
				ST_MEAN: begin
					if (cnt_q == 7'd1) begin
						res_q   <= mean_sat;
						err_q   <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						rem_q <= rem_nx;
						dvd_q <= dvd_nx;
						cnt_q <= cnt_q - 7'd1;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_mean_q <= res_q;
						out_err_q  <= err_q;
						wt_total_q <= '0;
						wv_total_q <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Load the dividend for the mean as the totals settle.
			if (state_q == ST_ACC) begin
				dvd_q <= wv_next[ACC_W-1] ? (~wv_next + ACC_W'(1)) : wv_next;
			end
		end
	end

endmodule

// ----- rtl/time_vertex_weighted_mean.sv -----
`timescale 1ns / 1ps

// Weighted mean over a root vertex and its neighbours across a window of time slices.
// Samples enter one word at a time on the s_axis channel; tlast marks the final
// sample of a root's set and tuser marks a sample of the root itself.
// Slice count and seven slice coefficients are written on the always-ready cfg channel;
// the user must do so only while the block is idle: the block itself does not enforce it.
// One result word leaves on m_axis per set, on its last sample: the mean in tdata
// and the zero-weight error flag in tuser.
// A front end classifies each sample and selects its coefficient; a two-entry queue
// parts it from the back end, which owns one shared restoring divider (one quotient
// bit a cycle), a 32 by 32 multiplier and the two accumulators.
// In the back end a skipped sample passes the idle and accumulate states; a root
// sample with zero coefficient adds the multiply state, a root sample a division for
// its weight, a neighbour sample a further division for the inverse link; the last
// sample of a set adds the mean division (none for zero total weight) and the hand-over.
// Reset clears the queue, the accumulators and the output, and sets slice count
// to 1 with all coefficients zero. When the receiver stalls, the result is held in
// the output register, the back end waits, and the queue fills before s_axis_tready
// drops.
module time_vertex_weighted_mean (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [31:0] sample_value, [63:32] link_weight, [66:64] slice_index, rest zero
	input  logic [71:0]                   s_axis_tdata,
	// [0] is_self
	input  logic                          s_axis_tuser,
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [31:0] mean_value
	output logic [31:0]                   m_axis_tdata,
	// [0] zero_weight_error
	output logic                          m_axis_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [twm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [twm_pkg::DATA_W-1:0]    cfg_data
);
	import twm_pkg::*;

	entry_t entry;
	entry_t head;
	logic   q_full;
	logic   q_valid;
	logic   q_pop;
	logic   push;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	twm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_value (s_axis_tdata[31:0]),
		.link_weight  (s_axis_tdata[63:32]),
		.slice_index  (s_axis_tdata[66:64]),
		.is_self      (s_axis_tuser),
		.last_sample  (s_axis_tlast),
		.entry        (entry)
	);

	twm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_valid),
		.head       (head)
	);

	twm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_mean  (m_axis_tdata),
		.out_error (m_axis_tuser)
	);

endmodule
